[rtl/des_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_pkg
// tables, widths and permutation helpers for the des core
// ----------------------------------------------------------------------------
package des_pkg;

    localparam int ROUNDS    = 16;
    localparam int BLOCK_W   = 64;
    localparam int SUBKEY_W  = 48;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DES_KEY      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 1'b1;

    typedef logic [7:0] t_tab8;

    localparam t_tab8 IP_TAB [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam t_tab8 FP_TAB [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam t_tab8 E_TAB [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1};
    localparam t_tab8 P_TAB [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};
    localparam t_tab8 PC1_TAB [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
    localparam t_tab8 PC2_TAB [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
        46,42,50,36,29,32};
    localparam t_tab8 ROT_TAB [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    typedef logic [3:0] t_nib;
    localparam t_nib SBOX [8][64] = '{
     '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
       4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
     '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
       0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
     '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
       13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
     '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
       10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
     '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
       4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
     '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
       9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
     '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
       1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
     '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
       7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    // tables count bits from 1 at the msb
    function automatic logic [63:0] perm_ip(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-IP_TAB[i]];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-FP_TAB[i]];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] x);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = x[64-PC1_TAB[i]];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] x);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = x[56-PC2_TAB[i]];
        return r;
    endfunction

    function automatic logic [27:0] rot28(input logic [27:0] v, input logic [7:0] n);
        return (n == 8'd2) ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
    endfunction

    // one feistel f function: expansion, key mix, s-boxes, p
    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] x;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0]  ch;
        for (int i = 0; i < 48; i++) x[47-i] = r[32-E_TAB[i]];
        x = x ^ k;
        for (int i = 0; i < 8; i++) begin
            ch = x[47-6*i -: 6];
            s[31-4*i -: 4] = SBOX[i][{ch[5], ch[0], ch[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32-P_TAB[i]];
        return p;
    endfunction

endpackage

[rtl/des_block_cipher_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_block_cipher_core
// pipelined des ecb engine, one round per stage
// ----------------------------------------------------------------------------
// Accepts one 64-bit block per cycle while o_stall is low. The pipe is an
// initial-permutation stage, sixteen round stages (one feistel round each)
// and a final-permutation output register. A result that is stalled at the
// output moves into a holding register. The pipe and the input stall only
// while that holding register is full, so o_stall is a register output. Once
// i_stall drops, the holding register empties, then blocks flow again at one
// per cycle. Round keys are held in a register stage behind the key and
// direction registers.
module des_block_cipher_core
    import des_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BLOCK_W-1:0]   i_data_block,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [BLOCK_W-1:0]   o_result_block
);

    localparam int STAGES = ROUNDS + 1;

    logic [63:0]         r_des_key;
    logic                r_decrypt_mode;
    logic [SUBKEY_W-1:0] w_subkey [ROUNDS];

    logic [STAGES-1:0]   r_vld;
    logic [31:0]         r_l [STAGES];
    logic [31:0]         r_r [STAGES];
    logic                r_out_vld;
    logic [BLOCK_W-1:0]  r_out;
    logic                r_skid_vld;
    logic [BLOCK_W-1:0]  r_skid;
    logic                w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_des_key      <= '0;
            r_decrypt_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DES_KEY:      r_des_key      <= i_cfg_data;
                REG_DECRYPT_MODE: r_decrypt_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    des_key_sched u_ks (
        .i_clk     (i_clk),
        .i_key     (r_des_key),
        .i_decrypt (r_decrypt_mode),
        .o_subkey  (w_subkey)
    );

    assign w_adv   = !r_skid_vld;
    assign o_stall = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld      <= {r_vld[STAGES-2:0], i_valid};
            r_out_vld  <= r_vld[STAGES-1];
            // stalled result parks in the holding register
            r_skid_vld <= r_out_vld && i_stall;
        end else if (!i_stall) begin
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [63:0] b;
        logic [31:0] t;
        if (w_adv) begin
            b = perm_ip(i_data_block);
            r_l[0] <= b[63:32];
            r_r[0] <= b[31:0];
            for (int i = 0; i < ROUNDS; i++) begin
                t = r_l[i] ^ feistel(r_r[i], w_subkey[i]);
                // no swap after the last round
                if (i == ROUNDS-1) begin
                    r_l[i+1] <= t;
                    r_r[i+1] <= r_r[i];
                end else begin
                    r_l[i+1] <= r_r[i];
                    r_r[i+1] <= t;
                end
            end
            r_out <= perm_fp({r_l[STAGES-1], r_r[STAGES-1]});
            if (r_out_vld && i_stall) r_skid <= r_out;
        end
    end

    assign o_valid        = r_skid_vld || r_out_vld;
    assign o_result_block = r_skid_vld ? r_skid : r_out;

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result_block)))
        else $error("stalled result changed");
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall without pending result");
    a_pipe_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_stall && r_vld[STAGES-1]) |=> o_valid)
        else $error("item lost at output");
`endif

endmodule

[rtl/des_key_sched.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_key_sched
// registered round-key table from the configured key and direction
// ----------------------------------------------------------------------------
module des_key_sched
    import des_pkg::*;
(
    input  logic                i_clk,
    input  logic [63:0]         i_key,
    input  logic                i_decrypt,
    output logic [SUBKEY_W-1:0] o_subkey [ROUNDS]
);

    logic [SUBKEY_W-1:0] n_subkey [ROUNDS];
    logic [SUBKEY_W-1:0] r_subkey [ROUNDS];

    always_comb begin
        logic [55:0] k56;
        logic [27:0] c;
        logic [27:0] d;
        logic [SUBKEY_W-1:0] ks [ROUNDS];
        k56 = perm_pc1(i_key);
        c = k56[55:28];
        d = k56[27:0];
        for (int i = 0; i < ROUNDS; i++) begin
            c = rot28(c, ROT_TAB[i]);
            d = rot28(d, ROT_TAB[i]);
            ks[i] = perm_pc2({c, d});
        end
        for (int i = 0; i < ROUNDS; i++)
            n_subkey[i] = i_decrypt ? ks[ROUNDS-1-i] : ks[i];
    end

    // user must change the key only while idle, not enforced here, so one register stage keeps up
    always_ff @(posedge i_clk) begin
        r_subkey <= n_subkey;
    end

    assign o_subkey = r_subkey;

endmodule
